FILE: rtl/qdf_pkg.sv
// qdf_pkg: shared types and constants of the quadratic drag force block
// no dependencies; imported by every module of the block
package qdf_pkg;

  // fraction bits of the Q16.16 values
  localparam int FRAC_BITS = 16;

  // configuration register index
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRAG_LINEAR    = 1'b0,
    CFG_DRAG_QUADRATIC = 1'b1
  } qdf_cfg_idx_t;

  // control bits that travel with each word down the pipeline
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
  } qdf_ctl_t;

endpackage

FILE: rtl/quadratic_drag_force_top.sv
// quadratic_drag_force_top: 2D linear plus quadratic drag force, pipelined
// depends on qdf_pkg, qdf_sqrt_cell and qdf_force_comp
//
// Usage:
//   Input channel in_valid/in_ready carries one velocity word (in_vel_x,
//   in_vel_y, signed Q16.16). Output channel out_valid/out_ready carries one
//   force word (out_force_x, out_force_y, saturated signed Q16.16, and
//   out_force_nonzero). Every input word gives exactly one output word.
//   Coefficients k1 (index 0) and k2 (index 1), unsigned Q16.16, are written
//   through cfg_we/cfg_index/cfg_wdata; the user must write them only while
//   the block holds no work, as the block itself does not enforce this.
// Pipeline: three stages for magnitude, squares and sum, one square root cell
//   per result bit, then factor multiply, factor add and three force stages.
// Throughput: one word per cycle while the skid register is empty; each
//   multiplier and compare-subtract has its own stage, so none is shared.
// Reset: clears the coefficients to zero and empties the pipeline.
// Stall: when the receiver holds out_ready low, the word at the end moves into
//   a skid register and the pipeline stops in the cycle after; in_ready is
//   low only while the skid register is full.
module quadratic_drag_force_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [VALUE_WIDTH-1:0]  in_vel_x,
  input  logic signed [VALUE_WIDTH-1:0]  in_vel_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [VALUE_WIDTH-1:0]  out_force_x,
  output logic signed [VALUE_WIDTH-1:0]  out_force_y,
  output logic                           out_force_nonzero,
  input  logic                           cfg_we,
  input  logic [qdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_WIDTH-1:0]         cfg_wdata
);
  import qdf_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int FW = 2 * W - FRAC_BITS + 1;

  // pipeline enable
  logic en;

  // coefficients
  logic [W-1:0] drag_lin_r;
  logic [W-1:0] drag_quad_r;

  // input magnitudes
  logic [W-1:0] vx_u;
  logic [W-1:0] vy_u;
  logic [W-1:0] ax_nxt;
  logic [W-1:0] ay_nxt;
  qdf_ctl_t     ctl_nxt;

  qdf_ctl_t       ctl_a_r;
  logic [W-1:0]   ax_a_r;
  logic [W-1:0]   ay_a_r;
  qdf_ctl_t       ctl_b_r;
  logic [W-1:0]   ax_b_r;
  logic [W-1:0]   ay_b_r;
  logic [2*W-1:0] sqx_b_r;
  logic [2*W-1:0] sqy_b_r;
  qdf_ctl_t       ctl_c_r;
  logic [W-1:0]   ax_c_r;
  logic [W-1:0]   ay_c_r;
  logic [2*W-1:0] sum_c_r;
  logic [2*W-1:0] sum_nxt;

  // square root chain taps
  qdf_ctl_t       ctl_s [0:W];
  logic [W-1:0]   ax_s  [0:W];
  logic [W-1:0]   ay_s  [0:W];
  logic [2*W-1:0] rem_s [0:W];
  logic [W-1:0]   root_s[0:W];

  qdf_ctl_t       ctl_d_r;
  logic [W-1:0]   ax_d_r;
  logic [W-1:0]   ay_d_r;
  logic [2*W-1:0] qprod_d_r;
  logic           spd_zero_d_r;
  qdf_ctl_t       ctl_e_r;
  logic [W-1:0]   ax_e_r;
  logic [W-1:0]   ay_e_r;
  logic [FW-1:0]  factor_e_r;
  logic [FW-1:0]  factor_nxt;
  logic           nz_e_r;

  // valid and flag alongside the force stages
  logic [2:0]     vld_fgh_r;
  logic [2:0]     nz_fgh_r;
  logic [W-1:0]   force_x_h;
  logic [W-1:0]   force_y_h;

  // skid register
  logic           sk_full_r;
  logic [W-1:0]   sk_fx_r;
  logic [W-1:0]   sk_fy_r;
  logic           sk_nz_r;

  assign en       = !sk_full_r;
  assign in_ready = en;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drag_lin_r  <= '0;
      drag_quad_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DRAG_LINEAR:    drag_lin_r  <= cfg_wdata;
        CFG_DRAG_QUADRATIC: drag_quad_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // magnitude and sign of each component
  always_comb begin
    vx_u          = in_vel_x;
    vy_u          = in_vel_y;
    ctl_nxt.valid = in_valid;
    ctl_nxt.neg_x = vx_u[W-1];
    ctl_nxt.neg_y = vy_u[W-1];
    ax_nxt        = vx_u[W-1] ? (~vx_u + W'(1)) : vx_u;
    ay_nxt        = vy_u[W-1] ? (~vy_u + W'(1)) : vy_u;
  end

  assign sum_nxt    = sqx_b_r + sqy_b_r;
  assign factor_nxt = FW'(drag_lin_r) + FW'(qprod_d_r[2*W-1:FRAC_BITS]);

  // control of the front stages and the factor stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r   <= '0;
      ctl_b_r   <= '0;
      ctl_c_r   <= '0;
      ctl_d_r   <= '0;
      ctl_e_r   <= '0;
      vld_fgh_r <= '0;
    end else if (en) begin
      ctl_a_r   <= ctl_nxt;
      ctl_b_r   <= ctl_a_r;
      ctl_c_r   <= ctl_b_r;
      ctl_d_r   <= ctl_s[W];
      ctl_e_r   <= ctl_d_r;
      vld_fgh_r <= {vld_fgh_r[1:0], ctl_e_r.valid};
    end
  end

  // payload of the front stages and the factor stages
  always_ff @(posedge clk) begin
    if (en) begin
      ax_a_r       <= ax_nxt;
      ay_a_r       <= ay_nxt;
      ax_b_r       <= ax_a_r;
      ay_b_r       <= ay_a_r;
      sqx_b_r      <= (2*W)'(ax_a_r) * (2*W)'(ax_a_r);
      sqy_b_r      <= (2*W)'(ay_a_r) * (2*W)'(ay_a_r);
      ax_c_r       <= ax_b_r;
      ay_c_r       <= ay_b_r;
      sum_c_r      <= sum_nxt;
      ax_d_r       <= ax_s[W];
      ay_d_r       <= ay_s[W];
      qprod_d_r    <= (2*W)'(drag_quad_r) * (2*W)'(root_s[W]);
      spd_zero_d_r <= (root_s[W] == '0);
      ax_e_r       <= ax_d_r;
      ay_e_r       <= ay_d_r;
      factor_e_r   <= factor_nxt;
      nz_e_r       <= !spd_zero_d_r && (factor_nxt != '0);
      nz_fgh_r     <= {nz_fgh_r[1:0], nz_e_r};
    end
  end

  // square root chain, most significant root bit first
  assign ctl_s[0]  = ctl_c_r;
  assign ax_s[0]   = ax_c_r;
  assign ay_s[0]   = ay_c_r;
  assign rem_s[0]  = sum_c_r;
  assign root_s[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    qdf_sqrt_cell #(
      .WIDTH (W),
      .BIT   (W - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (ctl_s[k]),
      .ax_i   (ax_s[k]),
      .ay_i   (ay_s[k]),
      .rem_i  (rem_s[k]),
      .root_i (root_s[k]),
      .ctl_o  (ctl_s[k+1]),
      .ax_o   (ax_s[k+1]),
      .ay_o   (ay_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .root_o (root_s[k+1])
    );
  end

  // force components
  qdf_force_comp #(
    .WIDTH (W)
  ) u_force_x (
    .clk      (clk),
    .en       (en),
    .mag_i    (ax_e_r),
    .neg_i    (ctl_e_r.neg_x),
    .factor_i (factor_e_r),
    .force_o  (force_x_h)
  );

  qdf_force_comp #(
    .WIDTH (W)
  ) u_force_y (
    .clk      (clk),
    .en       (en),
    .mag_i    (ay_e_r),
    .neg_i    (ctl_e_r.neg_y),
    .factor_i (factor_e_r),
    .force_o  (force_y_h)
  );

  // skid register catches the last word when the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_full_r <= 1'b0;
    end else if (!sk_full_r) begin
      if (vld_fgh_r[2] && !out_ready) begin
        sk_full_r <= 1'b1;
      end
    end else if (out_ready) begin
      sk_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_full_r) begin
      sk_fx_r <= force_x_h;
      sk_fy_r <= force_y_h;
      sk_nz_r <= nz_fgh_r[2];
    end
  end

  // output word from the skid register when full, else from the last stage
  assign out_valid         = sk_full_r || vld_fgh_r[2];
  assign out_force_x       = sk_full_r ? sk_fx_r : force_x_h;
  assign out_force_y       = sk_full_r ? sk_fy_r : force_y_h;
  assign out_force_nonzero = sk_full_r ? sk_nz_r : nz_fgh_r[2];

endmodule

FILE: rtl/qdf_sqrt_cell.sv
// qdf_sqrt_cell: one cell of the square root chain, settles one root bit
// depends on qdf_pkg for the control struct
module qdf_sqrt_cell #(
  parameter int WIDTH = 32,
  parameter int BIT   = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  qdf_pkg::qdf_ctl_t      ctl_i,
  input  logic [WIDTH-1:0]       ax_i,
  input  logic [WIDTH-1:0]       ay_i,
  input  logic [2*WIDTH-1:0]     rem_i,
  input  logic [WIDTH-1:0]       root_i,
  output qdf_pkg::qdf_ctl_t      ctl_o,
  output logic [WIDTH-1:0]       ax_o,
  output logic [WIDTH-1:0]       ay_o,
  output logic [2*WIDTH-1:0]     rem_o,
  output logic [WIDTH-1:0]       root_o
);
  import qdf_pkg::*;

  localparam int RW = 2 * WIDTH + 1;

  qdf_ctl_t           ctl_r;
  logic [WIDTH-1:0]   ax_r;
  logic [WIDTH-1:0]   ay_r;
  logic [2*WIDTH-1:0] rem_r;
  logic [WIDTH-1:0]   root_r;

  logic [RW-1:0]      trial;
  logic               take;
  logic [2*WIDTH-1:0] rem_nxt;
  logic [WIDTH-1:0]   root_nxt;

  // trial subtrahend (2*root + 2^bit) * 2^bit, kept one bit wider than the remainder
  always_comb begin
    trial    = (RW'(root_i) << (BIT + 1)) | (RW'(1) << (2 * BIT));
    take     = ({1'b0, rem_i} >= trial);
    rem_nxt  = take ? (rem_i - trial[2*WIDTH-1:0]) : rem_i;
    root_nxt = take ? (root_i | (WIDTH'(1) << BIT)) : root_i;
  end

  // control stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  // payload stage
  always_ff @(posedge clk) begin
    if (en) begin
      ax_r   <= ax_i;
      ay_r   <= ay_i;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign ctl_o  = ctl_r;
  assign ax_o   = ax_r;
  assign ay_o   = ay_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

FILE: rtl/qdf_force_comp.sv
// qdf_force_comp: three stage force component, |v| * factor, scaled, signed, saturated
// depends on qdf_pkg for the fraction width
module qdf_force_comp #(
  parameter int WIDTH = 32
) (
  input  logic                                         clk,
  input  logic                                         en,
  input  logic [WIDTH-1:0]                             mag_i,
  input  logic                                         neg_i,
  input  logic [2*WIDTH-qdf_pkg::FRAC_BITS:0]          factor_i,
  output logic [WIDTH-1:0]                             force_o
);
  import qdf_pkg::*;

  localparam int FW  = 2 * WIDTH - FRAC_BITS + 1;
  localparam int FHW = FW - WIDTH;
  localparam int PW  = WIDTH + FW;
  localparam int MW  = PW - FRAC_BITS;

  logic [2*WIDTH-1:0]     p_lo_r;
  logic [WIDTH+FHW-1:0]   p_hi_r;
  logic                   neg_f_r;
  logic [MW-1:0]          mag_r;
  logic                   neg_g_r;
  logic [WIDTH-1:0]       force_r;

  logic [PW-1:0]          prod_nxt;
  logic                   big;
  logic [WIDTH-1:0]       force_nxt;

  // stage one: split the factor into a low word and a high part
  always_ff @(posedge clk) begin
    if (en) begin
      p_lo_r  <= (2*WIDTH)'(mag_i) * (2*WIDTH)'(factor_i[WIDTH-1:0]);
      p_hi_r  <= (WIDTH+FHW)'(mag_i) * (WIDTH+FHW)'(factor_i[FW-1:WIDTH]);
      neg_f_r <= neg_i;
    end
  end

  // stage two: join the partial products and drop the fraction bits
  assign prod_nxt = {p_hi_r, {WIDTH{1'b0}}} + PW'(p_lo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= prod_nxt[PW-1:FRAC_BITS];
      neg_g_r <= neg_f_r;
    end
  end

  // stage three: force opposes the velocity, clamp to the signed range
  always_comb begin
    big = |mag_r[MW-1:WIDTH-1];
    if (neg_g_r) begin
      force_nxt = big ? {1'b0, {(WIDTH-1){1'b1}}} : mag_r[WIDTH-1:0];
    end else begin
      force_nxt = big ? {1'b1, {(WIDTH-1){1'b0}}} : (~mag_r[WIDTH-1:0] + WIDTH'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_r <= force_nxt;
    end
  end

  assign force_o = force_r;

endmodule

FILE: tb/tb_quadratic_drag_force_top.sv
// tb_quadratic_drag_force_top: self-checking bench for the 2D linear plus quadratic drag block
// depends on qdf_pkg and quadratic_drag_force_top; drives directed and random velocity words
// under random stalls, compares each force word with a bit-exact predictor or pinned row
module tb_quadratic_drag_force_top;
  import qdf_pkg::*;

  localparam int VW = 32;
  localparam int LAT = VW + 8;
  localparam int N_PHASES = 8;
  localparam int PHASE_WORDS = 142;
  localparam int LONG_STALL = 250;
  localparam int SMALL_VEL = 1 << 20;
  localparam logic [VW-1:0] POS_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] NEG_MAX = {1'b1, {(VW-1){1'b0}}};

  typedef struct packed {
    logic [VW-1:0] fx;
    logic [VW-1:0] fy;
    logic          nz;
  } force_t;

  typedef struct packed {
    logic [VW-1:0] k1;
    logic [VW-1:0] k2;
    logic [VW-1:0] vx;
    logic [VW-1:0] vy;
    logic          pinned;
    force_t        res;
  } drag_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [VW-1:0]  in_vel_x = '0;
  logic signed [VW-1:0]  in_vel_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [VW-1:0]  out_force_x;
  logic signed [VW-1:0]  out_force_y;
  logic                  out_force_nonzero;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [VW-1:0]         cfg_wdata = '0;

  // bench-side tag that travels with the word on the input channel
  logic                  in_pinned = 1'b0;
  force_t                in_pinned_force = '0;

  logic [VW-1:0]         coef_lin = '0;
  logic [VW-1:0]         coef_quad = '0;
  force_t                expected_force_q[$];
  int                    mismatch_cnt = 0;
  logic                  long_stall_req = 1'b0;

  quadratic_drag_force_top #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_vel_x          (in_vel_x),
    .in_vel_y          (in_vel_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_force_x       (out_force_x),
    .out_force_y       (out_force_y),
    .out_force_nonzero (out_force_nonzero),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // floor square root, one result bit per trial
  function automatic logic [VW-1:0] speed_sqrt(input logic [127:0] sumsq);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int i = VW - 1; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= sumsq)
        root = trial;
    end
    return root[VW-1:0];
  endfunction

  // one component: |v| * factor / 2^16, sign flipped against v, saturated
  function automatic logic [VW-1:0] force_part(input logic [VW-1:0] mag, input logic neg,
                                               input logic [127:0] factor);
    logic [127:0] prod;
    prod = (128'(mag) * factor) >> FRAC_BITS;
    if (neg)
      return (prod > 128'(POS_MAX)) ? POS_MAX : prod[VW-1:0];
    return (prod >= 128'(NEG_MAX)) ? NEG_MAX : (~prod[VW-1:0] + 1'b1);
  endfunction

  function automatic force_t drag_force(input logic [VW-1:0] vx, input logic [VW-1:0] vy);
    logic [VW-1:0]  ax;
    logic [VW-1:0]  ay;
    logic [VW-1:0]  speed;
    logic [127:0]   factor;
    force_t         r;
    ax = vx[VW-1] ? (~vx + 1'b1) : vx;
    ay = vy[VW-1] ? (~vy + 1'b1) : vy;
    speed = speed_sqrt(128'(ax) * 128'(ax) + 128'(ay) * 128'(ay));
    factor = 128'(coef_lin) + ((128'(coef_quad) * 128'(speed)) >> FRAC_BITS);
    r = '0;
    // still velocity or a zero drag factor gives no force at all
    if (speed == '0 || factor == '0)
      return r;
    r.fx = force_part(ax, vx[VW-1], factor);
    r.fy = force_part(ay, vy[VW-1], factor);
    r.nz = 1'b1;
    return r;
  endfunction

  // mix of zeros, extremes, full-range, small and shifted velocities
  function automatic logic [VW-1:0] rand_vel();
    logic [VW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: begin
        case ($urandom_range(0, 3))
          0: v = NEG_MAX;
          1: v = POS_MAX;
          2: v = VW'(1);
          default: v = '1;
        endcase
      end
      2, 3: v = $urandom;
      4, 5, 6: v = VW'($urandom_range(0, 2 * SMALL_VEL)) - VW'(SMALL_VEL);
      default: v = VW'($signed($urandom) >>> $urandom_range(0, VW - 1));
    endcase
    return v;
  endfunction

  function automatic logic [VW-1:0] rand_coef();
    logic [VW-1:0] c;
    case ($urandom_range(0, 4))
      0: c = '0;
      1: c = '1;
      2: c = $urandom_range(0, 32'h0004_0000);
      3: c = $urandom;
      default: c = VW'(1) << $urandom_range(0, VW - 1);
    endcase
    return c;
  endfunction

  // directed words; pinned rows carry a result worked out by hand
  drag_row_t dir_rows [22] = '{
    // coefficients at reset: factor is zero
    '{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{32'h0, 32'h0, 1'b0}},
    '{32'h0, 32'h0, 32'h1234_5678, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0}},
    // pure linear drag, k1 = 1.0
    '{32'h1_0000, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0}},
    '{32'h1_0000, 32'h0, 32'h1_0000, 32'h0, 1'b1, '{32'hFFFF_0000, 32'h0, 1'b1}},
    '{32'h1_0000, 32'h0, 32'h0, 32'hFFFF_0000, 1'b1, '{32'h0, 32'h1_0000, 1'b1}},
    '{32'h1_0000, 32'h0, 32'h8000_0000, 32'h0, 1'b1, '{32'h7FFF_FFFF, 32'h0, 1'b1}},
    '{32'h1_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b1, '{32'h8000_0001, 32'h0, 1'b1}},
    '{32'h1_0000, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b1,
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1}},
    '{32'h1_0000, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
      '{32'h8000_0001, 32'h8000_0001, 1'b1}},
    '{32'h1_0000, 32'h0, 32'h3_0000, 32'h4_0000, 1'b1, '{32'hFFFD_0000, 32'hFFFC_0000, 1'b1}},
    '{32'h1_0000, 32'h0, 32'hFFFE_8000, 32'h2_8000, 1'b0, '0},
    // tiny linear coefficient: force truncates to zero but is flagged
    '{32'h1, 32'h0, 32'h1, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b1}},
    '{32'h1, 32'h0, 32'h1_0000, 32'h1_0000, 1'b0, '0},
    // pure quadratic drag, k2 = 1.0
    '{32'h0, 32'h1_0000, 32'h2_0000, 32'h0, 1'b1, '{32'hFFFC_0000, 32'h0, 1'b1}},
    '{32'h0, 32'h1_0000, 32'h1, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b1}},
    '{32'h0, 32'h1_0000, 32'hFFF0_0000, 32'h0012_3456, 1'b0, '0},
    // both coefficients at their maximum
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h1, 1'b0, '0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
      '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
    // quadratic term truncates the factor to zero
    '{32'h0, 32'h1, 32'h1, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0}},
    '{32'h0, 32'h1, 32'h100, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0}}
  };

  // offer one velocity word and hold it until the block takes it
  task automatic offer(input logic [VW-1:0] vx, input logic [VW-1:0] vy,
                       input logic pin, input force_t pin_res);
    in_valid <= 1'b1;
    in_vel_x <= vx;
    in_vel_y <= vy;
    in_pinned <= pin;
    in_pinned_force <= pin_res;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
  endtask

  task automatic idle(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // stop sending and wait until every word in flight has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_force_q.size() != 0)
      @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic set_coefs(input logic [VW-1:0] lin, input logic [VW-1:0] quad);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DRAG_LINEAR;
    cfg_wdata <= lin;
    @(posedge clk);
    cfg_index <= CFG_DRAG_QUADRATIC;
    cfg_wdata <= quad;
    @(posedge clk);
    cfg_we <= 1'b0;
    coef_lin = lin;
    coef_quad = quad;
  endtask

  // sender: reset, directed table, then random phases in bursts
  initial begin : stimulus
    int     burst_left;
    force_t no_pin;
    no_pin = '0;
    burst_left = $urandom_range(1, 40);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].k1 != coef_lin || dir_rows[i].k2 != coef_quad) begin
        drain();
        set_coefs(dir_rows[i].k1, dir_rows[i].k2);
      end
      offer(dir_rows[i].vx, dir_rows[i].vy, dir_rows[i].pinned, dir_rows[i].res);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      set_coefs(rand_coef(), rand_coef());
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // long receiver hold-off while words keep coming
        if (ph == 2 && n == 30)
          long_stall_req = 1'b1;
        // sender pause until the pipeline is empty
        if (ph == 5 && n == 60)
          drain();
        offer(rand_vel(), rand_vel(), 1'b0, no_pin);
        burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0)
            idle($urandom_range(1, 6));
          burst_left = $urandom_range(1, 60);
        end
      end
    end

    drain();
    if (mismatch_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // receiver: stall pattern in modes of random length, plus one long hold-off
  initial begin : sink
    int stall_left;
    int mode;
    int mode_left;
    stall_left = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (long_stall_req) begin
        long_stall_req = 1'b0;
        stall_left = LONG_STALL - 1;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // record expectations on input handshakes, check words on output handshakes
  always @(posedge clk) begin : scoreboard
    force_t got;
    force_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_force_q.push_back(in_pinned ? in_pinned_force : drag_force(in_vel_x, in_vel_y));
      if (out_valid && out_ready) begin
        got = '{out_force_x, out_force_y, out_force_nonzero};
        if (expected_force_q.size() == 0) begin
          $error("unexpected output word: force_x %h force_y %h force_nonzero %b",
                 got.fx, got.fy, got.nz);
          mismatch_cnt++;
        end else begin
          want = expected_force_q.pop_front();
          if (got.fx !== want.fx) begin
            $error("force_x expected %h got %h", want.fx, got.fx);
            mismatch_cnt++;
          end
          if (got.fy !== want.fy) begin
            $error("force_y expected %h got %h", want.fy, got.fy);
            mismatch_cnt++;
          end
          if (got.nz !== want.nz) begin
            $error("force_nonzero expected %b got %b", want.nz, got.nz);
            mismatch_cnt++;
          end
        end
      end
    end
  end

endmodule
